// ===== rtl/core/riot_interval_timer_port_unit_macros.svh =====
// Assertion macros shared by the interval timer port unit.
`ifndef RIOT_INTERVAL_TIMER_PORT_UNIT_MACROS_SVH
`define RIOT_INTERVAL_TIMER_PORT_UNIT_MACROS_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define RITP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define RITP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ritp_pkg.sv =====
// Shared types and constants of the interval timer port unit.
package ritp_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } ritp_op_type;

   localparam logic [15:0] ADDR_SWCHA  = 16'h0280;
   localparam logic [15:0] ADDR_SWACNT = 16'h0281;
   localparam logic [15:0] ADDR_SWCHB  = 16'h0282;
   localparam logic [15:0] ADDR_SWBCNT = 16'h0283;
   localparam logic [15:0] ADDR_INTIM  = 16'h0284;
   localparam logic [15:0] ADDR_INSTAT = 16'h0285;
   localparam logic [15:0] ADDR_TIM1   = 16'h0294;
   localparam logic [15:0] ADDR_TIM8   = 16'h0295;
   localparam logic [15:0] ADDR_TIM64  = 16'h0296;
   localparam logic [15:0] ADDR_TIM1K  = 16'h0297;

   localparam logic [7:0]  SWCHB_VALUE = 8'h3F;

   localparam int          PRESCALE_W  = 11;
   localparam logic [PRESCALE_W-1:0] PRESCALE_1    = 11'd1;
   localparam logic [PRESCALE_W-1:0] PRESCALE_8    = 11'd8;
   localparam logic [PRESCALE_W-1:0] PRESCALE_64   = 11'd64;
   localparam logic [PRESCALE_W-1:0] PRESCALE_1024 = 11'd1024;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  joystick_lines;
   } ritp_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       bad_access;
   } ritp_result_type;

endpackage

// ===== rtl/core/riot_interval_timer_port_unit.sv =====
// Top level of the interval timer and I/O port unit.
//
// Each req_ word is a CPU clock tick, a bus read or a bus write; every word
// yields exactly one rsp_ word carrying read_data and bad_access, in order.
// Ticks and writes return read_data of zero.
// A word accepted into the input register is decoded from that register and
// applied to the timer state at the edge where its response word is loaded
// and offered on rsp_, which happens once the response register is free.
// Throughput: one word per cycle while rsp_ready is high, set by the single
// decode and update path between the input and response registers.
// When the receiver holds rsp_ready low, the response word waits in its
// register and one more word may enter the input register; req_ready then
// falls until the response is taken.
// Reset (synchronous, active high) empties both registers, sets the timer to
// zero with a prescale of one and clears both underflow flags and the
// start-pending flag.
`include "riot_interval_timer_port_unit_macros.svh"

module riot_interval_timer_port_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_joystick_lines,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_bad_access
);

   ritp_pkg::ritp_item_type   req_item;
   ritp_pkg::ritp_item_type   stage_item;
   ritp_pkg::ritp_result_type result;
   logic                      stage_valid;
   logic                      advance;
   logic                      rsp_valid_ff, rsp_valid_in;
   ritp_pkg::ritp_result_type rsp_data_ff;

   assign req_item.operation      = req_operation;
   assign req_item.address        = req_address;
   assign req_item.write_data     = req_write_data;
   assign req_item.joystick_lines = req_joystick_lines;

   // A word leaves the input register when the response register is empty or its word is taken.
   assign advance = stage_valid && (!rsp_valid_ff || rsp_ready);

   ritp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_item     (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   ritp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (stage_item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff.read_data;
   assign rsp_bad_access = rsp_data_ff.bad_access;

   `RITP_ASSERT_SAME(a_bad_reads_zero, rsp_valid && rsp_bad_access, rsp_read_data == 8'd0, "bad access with non-zero data")
   `RITP_ASSERT_SAME(a_stall_only_when_full, !req_ready, stage_valid && rsp_valid_ff && !rsp_ready, "input stalled without cause")
   `RITP_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid_ff, "advanced word did not reach response register")

endmodule

// ===== rtl/core/ritp_in_stage.sv =====
// Input register of the interval timer port unit.
module ritp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ritp_pkg::ritp_item_type in_item,
   input  logic                  advance,
   output logic                  stage_valid,
   output ritp_pkg::ritp_item_type stage_item
);

   logic                    valid_ff;
   logic                    valid_in;
   ritp_pkg::ritp_item_type item_ff;

   // The stage can take a new word when empty or when its word moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ===== rtl/core/ritp_core.sv =====
// Timer state, address decode and result generation for one word.
module ritp_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  ritp_pkg::ritp_item_type   item,
   output ritp_pkg::ritp_result_type result
);

   logic [7:0]                      timer_ff,    timer_in;
   logic [ritp_pkg::PRESCALE_W-1:0] interval_ff, interval_in;
   logic [ritp_pkg::PRESCALE_W-1:0] count_ff,    count_in;
   logic                            flag_read_ff,  flag_read_in;
   logic                            flag_write_ff, flag_write_in;
   logic                            pending_ff,    pending_in;

   always_comb begin
      logic [ritp_pkg::PRESCALE_W-1:0] count_inc;
      logic [ritp_pkg::PRESCALE_W-1:0] new_interval;

      timer_in      = timer_ff;
      interval_in   = interval_ff;
      count_in      = count_ff;
      flag_read_in  = flag_read_ff;
      flag_write_in = flag_write_ff;
      pending_in    = pending_ff;
      result        = '0;
      count_inc     = count_ff + 1'b1;
      new_interval  = '0;

      case (ritp_pkg::ritp_op_type'(item.operation))
         ritp_pkg::OP_TICK: begin
            if (!pending_ff) begin
               if (count_inc == interval_ff) begin
                  if (timer_ff == 8'd0) begin
                     flag_read_in  = 1'b1;
                     flag_write_in = 1'b1;
                  end
                  count_in = '0;
                  timer_in = timer_ff - 8'd1;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         ritp_pkg::OP_READ: begin
            // Any read arms a freshly written timer before it is answered.
            if (pending_ff) begin
               pending_in    = 1'b0;
               count_in      = interval_ff - 1'b1;
               flag_read_in  = 1'b0;
               flag_write_in = 1'b0;
            end
            case (item.address)
               ritp_pkg::ADDR_SWCHA: begin
                  result.read_data = ~{item.joystick_lines[3:0], item.joystick_lines[7:4]};
               end
               ritp_pkg::ADDR_SWACNT, ritp_pkg::ADDR_SWBCNT: begin
                  result.read_data = 8'd0;
               end
               ritp_pkg::ADDR_SWCHB: begin
                  result.read_data = ritp_pkg::SWCHB_VALUE;
               end
               ritp_pkg::ADDR_INTIM: begin
                  result.read_data = timer_ff;
               end
               ritp_pkg::ADDR_INSTAT: begin
                  result.read_data = {flag_write_in, flag_read_in, 6'd0};
                  flag_read_in     = 1'b0;
               end
               default: begin
                  result.bad_access = 1'b1;
               end
            endcase
         end
         ritp_pkg::OP_WRITE: begin
            case (item.address)
               ritp_pkg::ADDR_SWCHA, ritp_pkg::ADDR_SWACNT: begin
                  new_interval = '0;
               end
               ritp_pkg::ADDR_TIM1:  new_interval = ritp_pkg::PRESCALE_1;
               ritp_pkg::ADDR_TIM8:  new_interval = ritp_pkg::PRESCALE_8;
               ritp_pkg::ADDR_TIM64: new_interval = ritp_pkg::PRESCALE_64;
               ritp_pkg::ADDR_TIM1K: new_interval = ritp_pkg::PRESCALE_1024;
               default: begin
                  result.bad_access = 1'b1;
               end
            endcase
            if (new_interval != '0) begin
               interval_in = new_interval;
               timer_in    = item.write_data;
               pending_in  = 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff      <= 8'd0;
         interval_ff   <= ritp_pkg::PRESCALE_1;
         count_ff      <= '0;
         flag_read_ff  <= 1'b0;
         flag_write_ff <= 1'b0;
         pending_ff    <= 1'b0;
      end else if (fire) begin
         timer_ff      <= timer_in;
         interval_ff   <= interval_in;
         count_ff      <= count_in;
         flag_read_ff  <= flag_read_in;
         flag_write_ff <= flag_write_in;
         pending_ff    <= pending_in;
      end
   end

endmodule
